/* design/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, request and status codes, and the queue entry type.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_WORDS_DEF = 128;
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = 5;
    localparam int BLK_W         = 12;
    localparam int NUM_W         = 13;
    localparam int WCNT_W        = 8;
    localparam int REQ_W         = 2;
    localparam int ST_W          = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int S_DATA_W      = 16;
    localparam int M_DATA_W      = 16;

    localparam logic [NUM_W-1:0]     NUM_LIMIT = 13'd4096;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_CLOSED = 2'd1;
    localparam logic [ST_W-1:0] ST_NOFREE = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FS_OPEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BLK_W-1:0]  blk;
        logic [NUM_W-1:0]  lim;
        logic [WCNT_W-1:0] nwords;
        logic [ST_W-1:0]   st;
    } t_cmd;

endpackage

/* design/bba_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator front end
// Holds configuration, classifies requests and queues them for the back end.
// ----------------------------------------------------------------------------
module bba_front #(
    parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [1:0] req_type, [13:2] block_index, [15:14] zero
    input  logic [bba_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bba_pkg::NUM_W-1:0]     i_cfg_data,
    input  logic                          i_clearing,
    output logic                          o_q_valid,
    output bba_pkg::t_cmd                 o_q_cmd,
    input  logic                          i_q_pop
);

    localparam int MapBits = MAP_WORDS * bba_pkg::WORD_BITS;
    localparam int CapBits = (MapBits < 4096) ? MapBits : 4096;
    localparam logic [bba_pkg::NUM_W-1:0] LimCap = bba_pkg::NUM_W'(CapBits);

    logic                         r_fs_open;
    logic [bba_pkg::NUM_W-1:0]    r_num_blocks;
    bba_pkg::t_cmd                r_q [2];
    logic                         r_wp;
    logic                         r_rp;
    logic [1:0]                   r_cnt;

    logic [bba_pkg::REQ_W-1:0]    req;
    logic [bba_pkg::BLK_W-1:0]    blk;
    logic [bba_pkg::NUM_W-1:0]    lim;
    logic [bba_pkg::NUM_W:0]      lim_up;
    bba_pkg::t_cmd                cmd;
    logic                         push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_open    <= 1'b0;
            r_num_blocks <= bba_pkg::NUM_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bba_pkg::CFG_FS_OPEN:    r_fs_open    <= i_cfg_data[0];
                bba_pkg::CFG_NUM_BLOCKS: r_num_blocks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign req    = i_s_axis_tdata[1:0];
    assign blk    = i_s_axis_tdata[13:2];
    assign lim    = (r_num_blocks > LimCap) ? LimCap : r_num_blocks;
    assign lim_up = {1'b0, lim} + (bba_pkg::NUM_W+1)'(bba_pkg::WORD_BITS - 1);

    always_comb begin
        cmd.kind   = bba_pkg::KIND_DONE;
        cmd.blk    = blk;
        cmd.lim    = lim;
        cmd.nwords = bba_pkg::WCNT_W'(lim_up >> bba_pkg::BIT_W);
        cmd.st     = bba_pkg::ST_OK;
        if (!r_fs_open) begin
            cmd.st = bba_pkg::ST_CLOSED;
            if (req == bba_pkg::REQ_ALLOC) begin
                cmd.blk = '0;
            end
        end else if (req == bba_pkg::REQ_ALLOC) begin
            cmd.kind = bba_pkg::KIND_ALLOC;
        end else if (req == bba_pkg::REQ_FREE || req == bba_pkg::REQ_CHECK) begin
            if ({1'b0, blk} >= lim) begin
                cmd.st = bba_pkg::ST_RANGE;
            end else if (req == bba_pkg::REQ_FREE) begin
                cmd.kind = bba_pkg::KIND_FREE;
            end else begin
                cmd.kind = bba_pkg::KIND_CHECK;
            end
        end
    end

    assign o_s_axis_tready = !i_clearing && (r_cnt != 2'd2);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_cnt != 2'd0);
    assign o_q_cmd         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

/* design/bba_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator back end
// Owns the free map, walks it for allocation and drives the result register.
// ----------------------------------------------------------------------------
module bba_back #(
    parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  bba_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_clearing,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [11:0] block_out, [12] in_use, [14:13] status, [15] zero
    output logic [bba_pkg::M_DATA_W-1:0] o_m_axis_tdata
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RMW   = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    logic [bba_pkg::WORD_BITS-1:0] mem [MAP_WORDS];

    t_state                         r_state, n_state;
    logic [AW-1:0]                  r_clr, n_clr;
    logic [bba_pkg::WCNT_W-1:0]     r_ptr, n_ptr;
    bba_pkg::t_cmd                  r_cmd, n_cmd;
    logic [bba_pkg::WORD_BITS-1:0]  r_rd_data;
    logic                           r_out_valid, n_out_valid;
    logic [bba_pkg::BLK_W-1:0]      r_out_blk, n_out_blk;
    logic                           r_out_use, n_out_use;
    logic [bba_pkg::ST_W-1:0]       r_out_st, n_out_st;

    logic [AW-1:0]                  rd_addr;
    logic                           we;
    logic [AW-1:0]                  wa;
    logic [bba_pkg::WORD_BITS-1:0]  wd;
    logic                           out_free;
    logic [bba_pkg::NUM_W-1:0]      rem;
    logic [bba_pkg::WORD_BITS-1:0]  mask;
    logic [bba_pkg::WORD_BITS-1:0]  cand;
    logic [bba_pkg::BIT_W-1:0]      idx;
    logic [bba_pkg::WORD_BITS-1:0]  bit_m;

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid && out_free;

    assign rem   = r_cmd.lim - {r_ptr, bba_pkg::BIT_W'(0)};
    assign mask  = (rem >= bba_pkg::NUM_W'(bba_pkg::WORD_BITS)) ? bba_pkg::FULL_WORD :
                   ((bba_pkg::WORD_BITS'(1) << rem[bba_pkg::BIT_W-1:0]) -
                    bba_pkg::WORD_BITS'(1));
    assign cand  = r_rd_data & mask;
    assign bit_m = bba_pkg::WORD_BITS'(1) << r_cmd.blk[bba_pkg::BIT_W-1:0];

    always_comb begin
        idx = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                idx = bba_pkg::BIT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ptr       = r_ptr;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_blk   = r_out_blk;
        n_out_use   = r_out_use;
        n_out_st    = r_out_st;
        rd_addr     = '0;
        we          = 1'b0;
        wa          = '0;
        wd          = bba_pkg::FULL_WORD;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
                if (r_clr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (o_q_pop) begin
                    n_cmd = i_q_cmd;
                    case (i_q_cmd.kind)
                        bba_pkg::KIND_ALLOC: begin
                            if (i_q_cmd.nwords == '0) begin
                                n_out_valid = 1'b1;
                                n_out_blk   = '0;
                                n_out_use   = 1'b0;
                                n_out_st    = bba_pkg::ST_NOFREE;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        bba_pkg::KIND_FREE, bba_pkg::KIND_CHECK: begin
                            rd_addr = AW'(i_q_cmd.blk >> bba_pkg::BIT_W);
                            n_state = S_RMW;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_blk   = i_q_cmd.blk;
                            n_out_use   = 1'b0;
                            n_out_st    = i_q_cmd.st;
                        end
                    endcase
                end
            end
            S_RMW: begin
                n_out_valid = 1'b1;
                n_out_blk   = r_cmd.blk;
                n_out_st    = bba_pkg::ST_OK;
                n_state     = S_IDLE;
                if (r_cmd.kind == bba_pkg::KIND_FREE) begin
                    we        = 1'b1;
                    wa        = AW'(r_cmd.blk >> bba_pkg::BIT_W);
                    wd        = r_rd_data | bit_m;
                    n_out_use = 1'b0;
                end else begin
                    n_out_use = !(|(r_rd_data & bit_m));
                end
            end
            S_SCAN: begin
                if (cand != '0) begin
                    we          = 1'b1;
                    wa          = AW'(r_ptr);
                    wd          = r_rd_data & ~(bba_pkg::WORD_BITS'(1) << idx);
                    n_out_valid = 1'b1;
                    n_out_blk   = bba_pkg::BLK_W'({r_ptr, idx});
                    n_out_use   = 1'b0;
                    n_out_st    = bba_pkg::ST_OK;
                    n_state     = S_IDLE;
                end else if (r_ptr == r_cmd.nwords - bba_pkg::WCNT_W'(1)) begin
                    n_out_valid = 1'b1;
                    n_out_blk   = '0;
                    n_out_use   = 1'b0;
                    n_out_st    = bba_pkg::ST_NOFREE;
                    n_state     = S_IDLE;
                end else begin
                    rd_addr = AW'(r_ptr + bba_pkg::WCNT_W'(1));
                    n_ptr   = r_ptr + bba_pkg::WCNT_W'(1);
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_cmd     <= n_cmd;
        r_out_blk <= n_out_blk;
        r_out_use <= n_out_use;
        r_out_st  <= n_out_st;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_st, r_out_use, r_out_blk};

endmodule

/* design/bitmap_block_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// Free-block bitmap with allocate, free and check requests.
// ----------------------------------------------------------------------------
// After reset the core sweeps the free map to all free, one word per cycle,
// and takes no request until the sweep ends. In the back end, free and check
// do one registered map read, then free writes the word back with the bit set
// and check tests that bit; requests that fail early or carry the unused code
// are answered from the idle state. Allocate reads one 32-bit map word per
// cycle from word 0 up, walking words up to the first free block, at most
// ceil(limit / 32), 128 words with 4096 blocks. The single map read port sets
// that walk. A two-entry queue lets new requests arrive during a walk, and a
// result register holds an answer until the sink takes it.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
    parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [1:0] req_type, [13:2] block_index, [15:14] zero
    input  logic [bba_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [11:0] block_out, [12] in_use, [14:13] status, [15] zero
    output logic [bba_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bba_pkg::NUM_W-1:0]     i_cfg_data
);

    logic          q_valid;
    bba_pkg::t_cmd q_cmd;
    logic          q_pop;
    logic          clearing;

    bba_front #(
        .MAP_WORDS (MAP_WORDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_clearing      (clearing),
        .o_q_valid       (q_valid),
        .o_q_cmd         (q_cmd),
        .i_q_pop         (q_pop)
    );

    bba_back #(
        .MAP_WORDS (MAP_WORDS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_s_axis_tready)
        else $error("request accepted during map sweep");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("request started while result register full");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate, free, check and unused requests through the stream port,
// predicts every answer from a private copy of the free map and configuration,
// and compares each returned transaction field by field in order. Directed
// tests cover the closed file system, basic requests and the block limit
// edges; random traffic then runs through a series of configurations with
// bursty sending and a stalling sink.
// ----------------------------------------------------------------------------
module testbench;

    import bba_pkg::*;

    localparam int MAP_WORDS        = MAP_WORDS_DEF;
    localparam int IDLE_LIMIT       = 4000;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             in_use;
        logic [BLK_W-1:0] block_out;
    } alloc_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic [S_DATA_W-1:0]  req_data  = '0;
    logic                 rsp_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [NUM_W-1:0]     cfg_data  = '0;
    wire                  req_ready;
    wire                  rsp_valid;
    wire [M_DATA_W-1:0]   rsp_data;
    wire                  cfg_ready;

    logic [WORD_BITS-1:0] free_bits [MAP_WORDS];
    logic                 fs_open_q;
    logic [NUM_W-1:0]     num_blocks_q;
    alloc_result_t        pending_results [$];
    int                   n_errors   = 0;
    int                   idle_count = 0;

    bitmap_block_allocator_core #(
        .MAP_WORDS(MAP_WORDS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(req_valid),
        .o_s_axis_tready(req_ready),
        .i_s_axis_tdata (req_data),
        .o_m_axis_tvalid(rsp_valid),
        .i_m_axis_tready(rsp_ready),
        .o_m_axis_tdata (rsp_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int usable_limit();
        int lim;
        lim = int'(num_blocks_q);
        if (lim > MAP_WORDS * WORD_BITS) lim = MAP_WORDS * WORD_BITS;
        if (lim > int'(NUM_LIMIT)) lim = int'(NUM_LIMIT);
        return lim;
    endfunction

    function automatic alloc_result_t predict_request(input logic [REQ_W-1:0] req,
                                                      input logic [BLK_W-1:0] blk);
        alloc_result_t r;
        int lim;
        r.block_out = (req == REQ_ALLOC) ? '0 : blk;
        r.in_use    = 1'b0;
        r.status    = ST_OK;
        lim         = usable_limit();
        if (!fs_open_q) begin
            r.status = ST_CLOSED;
        end else if (req == REQ_ALLOC) begin
            r.status = ST_NOFREE;
            for (int b = 0; b < lim; b++) begin
                if (free_bits[b / WORD_BITS][b % WORD_BITS]) begin
                    free_bits[b / WORD_BITS][b % WORD_BITS] = 1'b0;
                    r.block_out = BLK_W'(b);
                    r.status    = ST_OK;
                    break;
                end
            end
        end else if (req == REQ_FREE || req == REQ_CHECK) begin
            if (int'(blk) >= lim) begin
                r.status = ST_RANGE;
            end else if (req == REQ_FREE) begin
                free_bits[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
            end else begin
                r.in_use = ~free_bits[blk / WORD_BITS][blk % WORD_BITS];
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [BLK_W-1:0] blk);
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= {2'b00, blk, req};
        do @(posedge clk); while (!req_ready);
        pending_results.push_back(predict_request(req, blk));
    endtask

    task automatic idle_gap(input int n);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (n - 1) @(posedge clk);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FS_OPEN) fs_open_q = val[0];
        else num_blocks_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic open, input logic [NUM_W-1:0] nblk);
        idle_gap(1);
        wait_for_results();
        repeat (4) @(posedge clk);
        write_reg(CFG_FS_OPEN, NUM_W'(open));
        write_reg(CFG_NUM_BLOCKS, nblk);
    endtask

    task automatic test_closed_fs();
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_FREE, 12'hFFF);
        send_request(REQ_CHECK, 12'd0);
        send_request(REQ_UNUSED, 12'hFFF);
    endtask

    task automatic test_alloc_free_check();
        idle_gap(1);
        wait_for_results();
        write_reg(CFG_FS_OPEN, NUM_W'(1));
        repeat (3) send_request(REQ_ALLOC, 12'hFFF);
        send_request(REQ_CHECK, 12'd1);
        send_request(REQ_CHECK, 12'hFFF);
        send_request(REQ_FREE, 12'd1);
        send_request(REQ_CHECK, 12'd1);
        send_request(REQ_ALLOC, 12'h555);
        send_request(REQ_FREE, 12'hFFF);
        send_request(REQ_UNUSED, 12'hABC);
    endtask

    task automatic test_block_limits();
        apply_config(1'b1, 13'd3);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_CHECK, 12'd3);
        send_request(REQ_FREE, 12'd2);
        send_request(REQ_ALLOC, 12'd0);
        apply_config(1'b1, 13'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_CHECK, 12'd0);
        send_request(REQ_FREE, 12'd0);
        apply_config(1'b1, 13'h1FFF);
        send_request(REQ_CHECK, 12'hFFF);
        apply_config(1'b0, NUM_LIMIT);
        send_request(REQ_ALLOC, 12'd0);
    endtask

    task automatic run_phase(input logic open, input logic [NUM_W-1:0] nblk,
                             input int n_items, input int alloc_pct);
        int lim;
        int burst_left;
        int pick;
        bit steady;
        logic [REQ_W-1:0] req;
        logic [BLK_W-1:0] blk;
        apply_config(open, nblk);
        lim        = usable_limit();
        steady     = ($urandom_range(2, 0) == 0);
        burst_left = $urandom_range(20, 1);
        for (int k = 0; k < n_items; k++) begin
            if (!steady && burst_left == 0) begin
                idle_gap($urandom_range(12, 1));
                burst_left = $urandom_range(20, 1);
            end
            if ($urandom_range(59, 0) == 0) begin
                idle_gap(1);
                wait_for_results();
            end
            pick = $urandom_range(99, 0);
            if (pick < alloc_pct) req = REQ_ALLOC;
            else if (pick < 95) req = $urandom_range(1, 0) ? REQ_FREE : REQ_CHECK;
            else req = REQ_UNUSED;
            pick = $urandom_range(9, 0);
            if (pick < 7 && lim > 0) blk = BLK_W'($urandom_range(lim - 1, 0));
            else if (pick == 7) blk = BLK_W'(lim + $urandom_range(2, 0));
            else blk = BLK_W'($urandom);
            send_request(req, blk);
            burst_left--;
        end
    endtask

    task automatic test_random_traffic();
        run_phase(1'b1, 13'd4096, 400, 70);
        run_phase(1'b1, 13'd37, 300, 50);
        run_phase(1'b1, 13'd1, 100, 40);
        run_phase(1'b1, 13'd0, 40, 40);
        run_phase(1'b0, NUM_W'($urandom_range(4096, 0)), 60, 40);
        run_phase(1'b1, 13'h1FFF, 200, 45);
        run_phase(1'b1, 13'd64, 200, 50);
        repeat (3) run_phase(1'b1, NUM_W'($urandom_range(4096, 0)), 150, 45);
    endtask

    initial begin
        int mode;
        int span;
        int period;
        int hold;
        forever begin
            mode   = $urandom_range(2, 0);
            span   = $urandom_range(200, 20);
            period = $urandom_range(40, 4);
            hold   = $urandom_range(period - 1, 1);
            for (int k = 0; k < span; k++) begin
                @(negedge clk);
                case (mode)
                    0: begin
                        rsp_ready <= 1'b1;
                    end
                    1: begin
                        rsp_ready <= 1'($urandom_range(1, 0));
                    end
                    default: begin
                        rsp_ready <= ((k % period) >= hold);
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && rsp_valid && rsp_ready) begin
            got = alloc_result_t'(rsp_data[14:0]);
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: 0x%0h", rsp_data);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.block_out !== want.block_out) begin
                    $error("block_out mismatch: expected %0d, actual %0d",
                           want.block_out, got.block_out);
                    n_errors++;
                end
                if (got.in_use !== want.in_use) begin
                    $error("in_use mismatch: expected %0d, actual %0d", want.in_use, got.in_use);
                    n_errors++;
                end
                if (got.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        for (int w = 0; w < MAP_WORDS; w++) free_bits[w] = FULL_WORD;
        fs_open_q    = 1'b0;
        num_blocks_q = NUM_LIMIT;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_closed_fs();
        test_alloc_free_check();
        test_block_limits();
        test_random_traffic();
        idle_gap(1);
        wait_for_results();
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d result transactions never arrived", pending_results.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
